// ===== rtl/ffha_pkg.sv =====
// ffha_pkg: shared constants, status codes and sequencer states of the heap allocator
// no dependencies; imported by every other file of the block
`default_nettype none

package ffha_pkg;

	localparam int unsigned HEAP_BYTES_DEF = 4096;
	localparam int unsigned GRAN           = 8;
	localparam int unsigned GRAN_SH        = 3;

	localparam int unsigned REQ_W  = 13;
	localparam int unsigned OFF_W  = 12;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned NEED_W = 11;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_NO_SPACE    = 3'd1,
		STAT_ZERO_SIZE   = 3'd2,
		STAT_OUT_OF_HEAP = 3'd3,
		STAT_DOUBLE_FREE = 3'd4,
		STAT_NOT_START   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_SPLIT,
		FSM_MERGE,
		FSM_NEXT_ADDR,
		FSM_NEXT_CHK,
		FSM_RESP
	} fsm_t;

endpackage

`default_nettype wire

// ===== rtl/ffha_if.sv =====
// ffha_req_if / ffha_rsp_if: valid-ready channels for request and result beats
// depends on ffha_pkg for field widths
`default_nettype none

interface ffha_req_if;
	import ffha_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [REQ_W-1:0]     request_bytes;
	logic [OFF_W-1:0]     payload_offset;
	modport source (output valid, kind, request_bytes, payload_offset, input ready);
	modport sink   (input valid, kind, request_bytes, payload_offset, output ready);
endinterface

interface ffha_rsp_if;
	import ffha_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [OFF_W-1:0]     offset;
	modport source (output valid, status, offset, input ready);
	modport sink   (input valid, status, offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffha_hdr_store.sv =====
// ffha_hdr_store: single-port chunk header memory, one {free, size in slots} word per slot
// sweeps every entry to zero after reset; depends on ffha_pkg
`default_nettype none

module ffha_hdr_store #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        wr_en,
	input  wire logic                                        rd_en,
	input  wire logic [$clog2(HEAP_BYTES/ffha_pkg::GRAN)-1:0] addr,
	input  wire logic [$clog2(HEAP_BYTES/ffha_pkg::GRAN+1):0] wdata,
	output logic      [$clog2(HEAP_BYTES/ffha_pkg::GRAN+1):0] rdata,
	output logic                                             busy
);
	import ffha_pkg::*;

	localparam int unsigned SLOTS = HEAP_BYTES / GRAN;
	localparam int unsigned AW    = $clog2(SLOTS);
	localparam int unsigned SW    = $clog2(SLOTS + 1);
	localparam int unsigned HW    = SW + 1;

	logic [HW-1:0] mem [SLOTS];
	logic [HW-1:0] rdata_q;
	logic [AW-1:0] clr_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(SLOTS - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(clr_q) == AW'(SLOTS - 1))
		else $error("clearing pass ended early");

	a_no_access_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (!wr_en && !rd_en))
		else $error("header access during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/ffha_seq.sv =====
// ffha_seq: chunk walk sequencer around one shared add/subtract unit
// drives the header store port; depends on ffha_pkg and ffha_req_if
`default_nettype none

module ffha_seq #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	ffha_req_if.sink                                         req,
	output logic                                             res_valid,
	input  wire logic                                        res_ready,
	output ffha_pkg::status_t                                res_status,
	output logic      [ffha_pkg::OFF_W-1:0]                  res_offset,
	output logic                                             mem_wr,
	output logic                                             mem_rd,
	output logic      [$clog2(HEAP_BYTES/ffha_pkg::GRAN)-1:0] mem_addr,
	output logic      [$clog2(HEAP_BYTES/ffha_pkg::GRAN+1):0] mem_wdata,
	input  wire logic [$clog2(HEAP_BYTES/ffha_pkg::GRAN+1):0] mem_rdata,
	input  wire logic                                        mem_busy
);
	import ffha_pkg::*;

	localparam int unsigned SLOTS = HEAP_BYTES / GRAN;
	localparam int unsigned AW    = $clog2(SLOTS);
	localparam int unsigned SW    = $clog2(SLOTS + 1);
	localparam int unsigned CW    = ((SW > NEED_W) ? SW : NEED_W) + 1;
	localparam int unsigned HBW   = $clog2(HEAP_BYTES + 1);
	localparam int unsigned PW    = (HBW > OFF_W) ? HBW : OFF_W;

	fsm_t              state_q, state_d;
	logic              kind_q, kind_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic [NEED_W-1:0] need1_q, need1_d;
	logic [CW-1:0]     r_q, r_d;
	logic [AW-1:0]     p_q, p_d;
	logic [CW-1:0]     acc_q, acc_d;
	logic [CW-1:0]     addr2_q, addr2_d;
	status_t           status_q, status_d;
	logic [OFF_W-1:0]  offset_q, offset_d;

	logic [CW-1:0]     add_a, add_b, add_sum;
	logic              add_sub;

	logic [CW-1:0]     cs;
	logic              fr;
	logic [CW-1:0]     p_ext;
	logic [NEED_W-1:0] need_base;
	logic [CW+2:0]     fit_off;
	logic              accept;

	// shared add/subtract unit
	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + CW'(add_sub);

	assign cs        = CW'(mem_rdata[SW-1:0]);
	assign fr        = mem_rdata[SW];
	assign p_ext     = CW'(p_q);
	assign need_base = NEED_W'(req.request_bytes[REQ_W-1:GRAN_SH])
		+ NEED_W'(|req.request_bytes[GRAN_SH-1:0]);
	assign fit_off   = {p_ext, 3'b000} + (CW+3)'(GRAN);
	assign accept    = req.valid && req.ready;

	assign req.ready  = (state_q == FSM_IDLE) && !mem_busy;
	assign res_valid  = (state_q == FSM_RESP);
	assign res_status = status_q;
	assign res_offset = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		need_q   <= need_d;
		need1_q  <= need1_d;
		r_q      <= r_d;
		p_q      <= p_d;
		acc_q    <= acc_d;
		addr2_q  <= addr2_d;
		status_q <= status_d;
		offset_q <= offset_d;
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		need_d    = need_q;
		need1_d   = need1_q;
		r_d       = r_q;
		p_d       = p_q;
		acc_d     = acc_q;
		addr2_d   = addr2_q;
		status_d  = status_q;
		offset_d  = offset_q;
		add_a     = p_ext;
		add_b     = cs;
		add_sub   = 1'b0;
		mem_wr    = 1'b0;
		mem_rd    = 1'b0;
		mem_addr  = p_q;
		mem_wdata = '0;
		case (state_q)
			FSM_IDLE: begin
				add_a   = CW'(req.payload_offset[OFF_W-1:GRAN_SH]);
				add_b   = CW'(1);
				add_sub = 1'b1;
				if (accept) begin
					kind_d   = req.kind;
					need_d   = need_base + NEED_W'(1);
					need1_d  = need_base + NEED_W'(2);
					r_d      = add_sum;
					p_d      = '0;
					offset_d = '0;
					status_d = STAT_OK;
					if (req.kind == KIND_ALLOC) begin
						if (req.request_bytes == '0) begin
							status_d = STAT_ZERO_SIZE;
							state_d  = FSM_RESP;
						end else begin
							mem_rd   = 1'b1;
							mem_addr = '0;
							state_d  = FSM_WALK;
						end
					end else if (PW'(req.payload_offset) >= PW'(HEAP_BYTES)) begin
						status_d = STAT_OUT_OF_HEAP;
						state_d  = FSM_RESP;
					end else if (req.payload_offset[OFF_W-1:GRAN_SH] == '0
							|| req.payload_offset[GRAN_SH-1:0] != '0) begin
						status_d = STAT_NOT_START;
						state_d  = FSM_RESP;
					end else begin
						mem_rd   = 1'b1;
						mem_addr = '0;
						state_d  = FSM_WALK;
					end
				end
			end
			FSM_WALK: begin
				add_a = p_ext;
				add_b = cs;
				if (kind_q == KIND_ALLOC) begin
					if (cs == '0) begin
						add_b = CW'(need_q);
						if (p_q == '0 && CW'(need_q) <= CW'(SLOTS)) begin
							// unused heap: format it
							mem_wr    = 1'b1;
							mem_addr  = '0;
							mem_wdata = {1'b0, SW'(need_q)};
							addr2_d   = add_sum;
							acc_d     = CW'(SLOTS);
							offset_d  = OFF_W'(GRAN);
							state_d   = FSM_SPLIT;
						end else begin
							status_d = STAT_NO_SPACE;
							state_d  = FSM_RESP;
						end
					end else if (fr && cs > CW'(need_q)) begin
						add_b     = CW'(need_q);
						mem_wr    = 1'b1;
						mem_addr  = p_q;
						offset_d  = fit_off[OFF_W-1:0];
						if (cs == CW'(need1_q)) begin
							// eight-byte leftover stays with the chunk
							mem_wdata = {1'b0, SW'(cs)};
							state_d   = FSM_RESP;
						end else begin
							mem_wdata = {1'b0, SW'(need_q)};
							addr2_d   = add_sum;
							acc_d     = cs;
							state_d   = FSM_SPLIT;
						end
					end else if (add_sum < CW'(SLOTS)) begin
						p_d      = add_sum[AW-1:0];
						mem_rd   = 1'b1;
						mem_addr = add_sum[AW-1:0];
					end else begin
						status_d = STAT_NO_SPACE;
						state_d  = FSM_RESP;
					end
				end else begin
					if (cs == '0) begin
						status_d = STAT_NOT_START;
						state_d  = FSM_RESP;
					end else if (add_sum == r_q && fr) begin
						// free chunk just before: merge into it
						acc_d    = cs;
						mem_rd   = 1'b1;
						mem_addr = r_q[AW-1:0];
						state_d  = FSM_MERGE;
					end else if (p_ext == r_q) begin
						if (fr) begin
							status_d = STAT_DOUBLE_FREE;
							state_d  = FSM_RESP;
						end else begin
							acc_d   = cs;
							state_d = FSM_NEXT_ADDR;
						end
					end else if (add_sum < CW'(SLOTS)) begin
						p_d      = add_sum[AW-1:0];
						mem_rd   = 1'b1;
						mem_addr = add_sum[AW-1:0];
					end else begin
						status_d = STAT_NOT_START;
						state_d  = FSM_RESP;
					end
				end
			end
			FSM_SPLIT: begin
				add_a   = acc_q;
				add_b   = CW'(need_q);
				add_sub = 1'b1;
				if (addr2_q < CW'(SLOTS)) begin
					mem_wr    = 1'b1;
					mem_addr  = addr2_q[AW-1:0];
					mem_wdata = {1'b1, add_sum[SW-1:0]};
				end
				state_d = FSM_RESP;
			end
			FSM_MERGE: begin
				add_a   = acc_q;
				add_b   = cs;
				acc_d   = add_sum;
				state_d = FSM_NEXT_ADDR;
			end
			FSM_NEXT_ADDR: begin
				add_a = p_ext;
				add_b = acc_q;
				if (add_sum < CW'(SLOTS)) begin
					mem_rd   = 1'b1;
					mem_addr = add_sum[AW-1:0];
					state_d  = FSM_NEXT_CHK;
				end else begin
					mem_wr    = 1'b1;
					mem_addr  = p_q;
					mem_wdata = {1'b1, acc_q[SW-1:0]};
					state_d   = FSM_RESP;
				end
			end
			FSM_NEXT_CHK: begin
				add_a     = acc_q;
				add_b     = cs;
				mem_wr    = 1'b1;
				mem_addr  = p_q;
				mem_wdata = {1'b1, fr ? add_sum[SW-1:0] : acc_q[SW-1:0]};
				state_d   = FSM_RESP;
			end
			FSM_RESP: begin
				if (res_ready) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd && mem_wr))
		else $error("header store read and write in one cycle");

	a_walk_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK) |-> $past(mem_rd))
		else $error("walk step without header read");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != FSM_IDLE))
		else $error("accepted beat not taken up");

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// Sequence: an item is issued from idle, then the walk reads one chunk header per step,
// then header writes or merge reads follow; the result beat is registered after the response state.
// Throughput: one item at a time; the walk is bounded by the single-port header store,
// which reads one header per cycle.
// Reset: asynchronous; afterwards a clearing pass over all HEAP_BYTES/8 header slots
// (512 at 4096 bytes) zeroes the header store, and no request beat is taken until it ends.
`default_nettype none

module first_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);
	import ffha_pkg::*;

	localparam int unsigned SLOTS = HEAP_BYTES / GRAN;
	localparam int unsigned AW    = $clog2(SLOTS);
	localparam int unsigned HW    = $clog2(SLOTS + 1) + 1;

	logic             res_valid;
	logic             res_ready;
	status_t          res_status;
	logic [OFF_W-1:0] res_offset;
	logic             mem_wr;
	logic             mem_rd;
	logic [AW-1:0]    mem_addr;
	logic [HW-1:0]    mem_wdata;
	logic [HW-1:0]    mem_rdata;
	logic             mem_busy;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [OFF_W-1:0] out_offset_q;

	ffha_seq #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_status (res_status),
		.res_offset (res_offset),
		.mem_wr     (mem_wr),
		.mem_rd     (mem_rd),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.mem_busy   (mem_busy)
	);

	ffha_hdr_store #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mem_wr),
		.rd_en  (mem_rd),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	// result beat register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_status_q <= res_status;
			out_offset_q <= res_offset;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.offset = out_offset_q;

endmodule

`default_nettype wire
